[src/expected_reciprocal_rank_accum_macros.svh]
// ---------------------------------------------------------------------------
// ERR accumulator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef EXPECTED_RECIPROCAL_RANK_ACCUM_MACROS_SVH
`define EXPECTED_RECIPROCAL_RANK_ACCUM_MACROS_SVH

// Same-cycle implication.
`define ERRAC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("errac assertion failed");

// Next-cycle implication.
`define ERRAC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("errac assertion failed");

`endif

[src/errac_pkg.sv]
// ---------------------------------------------------------------------------
// ERR accumulator package
// Widths, fixed-point constants and the queue item shared by the modules.
// ---------------------------------------------------------------------------
package errac_pkg;

   localparam int FRAC_BITS  = 32;
   localparam int RANK_BITS  = 16;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int PROD_W     = 2 * FRAC_BITS;
   localparam int CNT_W      = $clog2(Q_W + 1);
   localparam int SHIFT_W    = $clog2(FRAC_BITS + 1);
   localparam int LEVEL_W    = 4;
   localparam int CFG_W      = 5;
   localparam int NUMER_W    = 12;
   localparam int RANK_OUT_W = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [Q_W-1:0]       ONE_Q    = Q_W'(1) << FRAC_BITS;
   localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
   localparam logic [RANK_BITS-1:0] RANK_ONE = RANK_BITS'(1);

   localparam logic [CFG_W-1:0]   LEVELS_RESET = CFG_W'(6);
   localparam logic [CFG_W-1:0]   LEVELS_MIN   = CFG_W'(1);
   localparam logic [CFG_W-1:0]   LEVELS_MAX   = CFG_W'(16);
   localparam logic [LEVEL_W-1:0] GAIN_FLOOR   = LEVEL_W'(3);

   // One classified document waiting for the arithmetic back end.
   typedef struct packed {
      logic [FRAC_BITS-1:0] gain;
      logic                 last;
   } item_type;

endpackage

[src/errac_front.sv]
// ---------------------------------------------------------------------------
// ERR accumulator front end
// Holds the level count register and turns each level into its gain.
// ---------------------------------------------------------------------------
module errac_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [errac_pkg::CFG_W-1:0]    csr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [errac_pkg::LEVEL_W-1:0]  doc_grade,
   input  logic                           query_last,
   input  logic                           q_full,
   output logic                           q_push,
   output errac_pkg::item_type            q_item
);

   logic [errac_pkg::CFG_W-1:0]   num_levels_ff;
   logic [errac_pkg::CFG_W-1:0]   num_levels_in;
   logic [errac_pkg::CFG_W-1:0]   levels;
   logic [errac_pkg::LEVEL_W-1:0] level_top;
   logic [errac_pkg::LEVEL_W-1:0] level;
   logic [errac_pkg::NUMER_W-1:0] numer;
   logic [errac_pkg::SHIFT_W-1:0] shift;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      num_levels_in = num_levels_ff;
      if (csr_valid) begin
         num_levels_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= errac_pkg::LEVELS_RESET;
      end else begin
         num_levels_ff <= num_levels_in;
      end
   end

   // Clamp the register and the level, then gain = (2^(L-3)-1) / 2^(levels-1),
   // which is an exact left shift in Q0.32 since levels-1 never exceeds 15.
   always_comb begin
      if (num_levels_ff < errac_pkg::LEVELS_MIN) begin
         levels = errac_pkg::LEVELS_MIN;
      end else if (num_levels_ff > errac_pkg::LEVELS_MAX) begin
         levels = errac_pkg::LEVELS_MAX;
      end else begin
         levels = num_levels_ff;
      end
      level_top = errac_pkg::LEVEL_W'(levels - errac_pkg::LEVELS_MIN);
      level     = (doc_grade > level_top) ? level_top : doc_grade;
      numer     = (errac_pkg::NUMER_W'(1) << (level - errac_pkg::GAIN_FLOOR))
                  - errac_pkg::NUMER_W'(1);
      shift     = errac_pkg::SHIFT_W'(errac_pkg::FRAC_BITS)
                  - errac_pkg::SHIFT_W'(level_top);
      q_item.last = query_last;
      if (level > errac_pkg::GAIN_FLOOR) begin
         q_item.gain = errac_pkg::FRAC_BITS'(numer) << shift;
      end else begin
         q_item.gain = '0;
      end
   end

endmodule

[src/errac_fifo.sv]
// ---------------------------------------------------------------------------
// ERR accumulator item queue
// Two-entry queue that decouples the front end from the arithmetic.
// ---------------------------------------------------------------------------
module errac_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  errac_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output errac_pkg::item_type head_item
);

   errac_pkg::item_type                   entry_ff [errac_pkg::QUEUE_DEPTH];
   logic [errac_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [errac_pkg::QPTR_W-1:0]          wr_ptr_in;
   logic [errac_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [errac_pkg::QPTR_W-1:0]          rd_ptr_in;
   logic [errac_pkg::QCNT_W-1:0]          count_ff;
   logic [errac_pkg::QCNT_W-1:0]          count_in;
   logic                                  do_pop;

   assign full      = (count_ff == errac_pkg::QCNT_W'(errac_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + errac_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + errac_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + errac_pkg::QCNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - errac_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/errac_back.sv]
// ---------------------------------------------------------------------------
// ERR accumulator back end
// Multiplies, divides by the rank and updates the query state per document.
// ---------------------------------------------------------------------------
`include "expected_reciprocal_rank_accum_macros.svh"

module errac_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  errac_pkg::item_type               q_item,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [errac_pkg::Q_W-1:0]         err_value,
   output logic [errac_pkg::RANK_OUT_W-1:0]  rank_out,
   output logic                              is_final
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADJ,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                              state_ff, state_in;
   logic [errac_pkg::Q_W-1:0]              p_ff, p_in;
   logic [errac_pkg::Q_W-1:0]              err_ff, err_in;
   logic [errac_pkg::RANK_BITS-1:0]        rank_ff, rank_in;
   logic [errac_pkg::FRAC_BITS-1:0]        gain_ff, gain_in;
   logic                                   last_ff, last_in;
   logic [errac_pkg::PROD_W-1:0]           prod_ff, prod_in;
   logic [errac_pkg::Q_W-1:0]              hi_ff, hi_in;
   logic                                   frac_ff, frac_in;
   logic [errac_pkg::Q_W-1:0]              quo_ff, quo_in;
   logic [errac_pkg::RANK_BITS-1:0]        rem_ff, rem_in;
   logic [errac_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [errac_pkg::Q_W-1:0]              out_err_ff, out_err_in;
   logic [errac_pkg::RANK_OUT_W-1:0]       out_rank_ff, out_rank_in;
   logic                                   out_last_ff, out_last_in;

   logic [errac_pkg::PROD_W:0]             x_full;
   logic [errac_pkg::RANK_BITS:0]          rem_shift;
   logic [errac_pkg::RANK_BITS:0]          rem_diff;
   logic                                   quo_bit;
   logic [errac_pkg::Q_W:0]                err_sum;
   logic [errac_pkg::Q_W-1:0]              p_drop;
   logic                                   out_free;
   logic                                   done_fire;
   logic                                   state_cleared;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign done_fire  = (state_ff == ST_DONE) && out_free;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign rsp_tvalid = out_valid_ff;
   assign err_value  = out_err_ff;
   assign rank_out   = out_rank_ff;
   assign is_final   = out_last_ff;

   assign state_cleared = (p_ff == errac_pkg::ONE_Q) && (err_ff == '0)
                          && (rank_ff == errac_pkg::RANK_ONE);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      err_in       = err_ff;
      rank_in      = rank_ff;
      gain_in      = gain_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      frac_in      = frac_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_err_in   = out_err_ff;
      out_rank_in  = out_rank_ff;
      out_last_in  = out_last_ff;

      // p * gain: low word through the multiplier, the integer bit of p
      // adds gain one word up.
      x_full = {1'b0, prod_ff}
               + (p_ff[errac_pkg::FRAC_BITS] ?
                  {1'b0, gain_ff, errac_pkg::FRAC_BITS'(0)} : '0);

      // One restoring division step, quotient shifted in from the bottom.
      rem_shift = {rem_ff, quo_ff[errac_pkg::Q_W-1]};
      rem_diff  = rem_shift - {1'b0, rank_ff};
      quo_bit   = (rem_shift >= {1'b0, rank_ff});

      err_sum = {1'b0, err_ff} + {1'b0, quo_ff};
      // 1 - gain in place of a second product: p - ceil(p*gain).
      p_drop  = hi_ff + errac_pkg::Q_W'(frac_ff);

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               gain_in  = q_item.gain;
               last_in  = q_item.last;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = p_ff[errac_pkg::FRAC_BITS-1:0] * gain_ff;
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            hi_in    = x_full[errac_pkg::PROD_W:errac_pkg::FRAC_BITS];
            frac_in  = |x_full[errac_pkg::FRAC_BITS-1:0];
            quo_in   = x_full[errac_pkg::PROD_W:errac_pkg::FRAC_BITS];
            rem_in   = '0;
            cnt_in   = errac_pkg::CNT_W'(errac_pkg::Q_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = quo_bit ? rem_diff[errac_pkg::RANK_BITS-1:0]
                             : rem_shift[errac_pkg::RANK_BITS-1:0];
            quo_in = {quo_ff[errac_pkg::Q_W-2:0], quo_bit};
            cnt_in = cnt_ff - errac_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = (err_sum > {1'b0, errac_pkg::ONE_Q}) ?
                              errac_pkg::ONE_Q : err_sum[errac_pkg::Q_W-1:0];
               out_rank_in  = errac_pkg::RANK_OUT_W'(rank_ff);
               out_last_in  = last_ff;
               if (last_ff) begin
                  p_in    = errac_pkg::ONE_Q;
                  err_in  = '0;
                  rank_in = errac_pkg::RANK_ONE;
               end else begin
                  p_in    = p_ff - p_drop;
                  err_in  = out_err_in;
                  rank_in = (rank_ff == errac_pkg::RANK_MAX) ? rank_ff
                            : rank_ff + errac_pkg::RANK_ONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= errac_pkg::ONE_Q;
         err_ff       <= '0;
         rank_ff      <= errac_pkg::RANK_ONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         err_ff       <= err_in;
         rank_ff      <= rank_in;
         out_valid_ff <= out_valid_in;
      end
      gain_ff     <= gain_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      frac_ff     <= frac_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      out_err_ff  <= out_err_in;
      out_rank_ff <= out_rank_in;
      out_last_ff <= out_last_in;
   end

   `ERRAC_ASSERT_IMP(a_stay_le_one, 1'b1, p_ff <= errac_pkg::ONE_Q)
   `ERRAC_ASSERT_IMP(a_err_le_one, 1'b1, err_ff <= errac_pkg::ONE_Q)
   `ERRAC_ASSERT_IMP(a_rank_nonzero, 1'b1, rank_ff != '0)
   `ERRAC_ASSERT_IMP(a_rem_below_rank, state_ff == ST_DIV, rem_ff < rank_ff)
   `ERRAC_ASSERT_NXT(a_query_cleared, done_fire && last_ff, state_cleared)

endmodule

[src/expected_reciprocal_rank_accum.sv]
// A request popped by the idle back end passes the multiply, adjust, 33-step restoring divide
// and done states; the back end takes no further request until its response is registered.
// The front end and a two-entry queue take up to two further requests while the divider runs.
// Reset (synchronous, active high) sets the level count to 6, the stay probability to one,
// ERR to zero, the rank to one, and empties the queue and the result register.
// ---------------------------------------------------------------------------
// Expected reciprocal rank accumulator
// Running ERR over the ranked documents of a query, in unsigned Q1.32.
// ---------------------------------------------------------------------------
module expected_reciprocal_rank_accum (
   input  logic        clock,
   input  logic        reset,
   // Configuration: number of relevance levels.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data,     // num_levels
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [3:0] doc_grade, [7:4] zero
   input  logic        req_tlast,    // query_last
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // [32:0] err_value, [48:33] rank_out, [55:49] zero
   output logic        rsp_tlast     // is_final
);

   // The front end classifies each request into a gain and queues it; the
   // back end owns the query state and runs multiply, adjust and divide.
   errac_pkg::item_type                    front_item;
   errac_pkg::item_type                    head_item;
   logic                                   q_push;
   logic                                   q_full;
   logic                                   q_pop;
   logic                                   q_not_empty;
   logic [errac_pkg::Q_W-1:0]              err_value;
   logic [errac_pkg::RANK_OUT_W-1:0]       rank_out;

   errac_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .doc_grade  (req_tdata[errac_pkg::LEVEL_W-1:0]),
      .query_last (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (front_item)
   );

   errac_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   errac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .err_value  (err_value),
      .rank_out   (rank_out),
      .is_final   (rsp_tlast)
   );

   // Pack the result fields from the lowest bit up, zero-filled to whole bytes.
   assign rsp_tdata = {7'b0, rank_out, err_value};

endmodule

[bench/err_response_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ERR response checker
// Watches the configuration, request and response channels of the ERR
// accumulator, predicts each response and compares it field by field.
// ---------------------------------------------------------------------------
module err_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          pending,
   output int          mismatch_count
);

   typedef struct packed {
      logic [errac_pkg::Q_W-1:0]       err;
      logic [errac_pkg::RANK_BITS-1:0] rank;
      logic                            final_doc;
   } score_type;

   logic [errac_pkg::CFG_W-1:0]     level_count;
   logic [errac_pkg::Q_W-1:0]       still_looking;
   logic [errac_pkg::Q_W-1:0]       err_sum;
   logic [errac_pkg::RANK_BITS-1:0] doc_rank;
   score_type                       expected_scores[$];

   // Accounts one document against the running query state and returns the
   // score that the block must report for it.
   function automatic score_type score_document(
         input logic [errac_pkg::LEVEL_W-1:0] level_in,
         input logic                          closes_query);
      logic [errac_pkg::CFG_W-1:0]   levels;
      logic [errac_pkg::LEVEL_W-1:0] level;
      logic [11:0]                   numer;
      logic [63:0]                   gain;
      logic [65:0]                   prod;
      logic [65:0]                   scaled;
      logic [errac_pkg::Q_W-1:0]     term;
      logic [errac_pkg::Q_W:0]       sum;
      score_type                     score;
      levels = level_count;
      if (levels < errac_pkg::LEVELS_MIN) levels = errac_pkg::LEVELS_MIN;
      if (levels > errac_pkg::LEVELS_MAX) levels = errac_pkg::LEVELS_MAX;
      level = level_in;
      if ({1'b0, level} > levels - 5'd1) level = errac_pkg::LEVEL_W'(levels - 5'd1);
      gain = '0;
      if (level > errac_pkg::GAIN_FLOOR) begin
         numer = 12'((12'd1 << (level - errac_pkg::GAIN_FLOOR)) - 12'd1);
         gain  = (64'(numer) << errac_pkg::FRAC_BITS) >> (levels - 5'd1);
      end
      prod   = 66'(still_looking) * 66'(gain);
      scaled = prod >> errac_pkg::FRAC_BITS;
      term   = errac_pkg::Q_W'(scaled / 66'(doc_rank));
      sum    = {1'b0, err_sum} + {1'b0, term};
      if (sum > {1'b0, errac_pkg::ONE_Q}) sum = {1'b0, errac_pkg::ONE_Q};
      err_sum = sum[errac_pkg::Q_W-1:0];
      score.err       = err_sum;
      score.rank      = doc_rank;
      score.final_doc = closes_query;
      prod          = 66'(still_looking) * (66'(errac_pkg::ONE_Q) - 66'(gain));
      still_looking = errac_pkg::Q_W'(prod >> errac_pkg::FRAC_BITS);
      if (doc_rank < errac_pkg::RANK_MAX) doc_rank = doc_rank + errac_pkg::RANK_ONE;
      if (closes_query) begin
         still_looking = errac_pkg::ONE_Q;
         err_sum       = '0;
         doc_rank      = errac_pkg::RANK_ONE;
      end
      return score;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count = mismatch_count + 1;
      $display("%0t: response %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         level_count   = errac_pkg::LEVELS_RESET;
         still_looking = errac_pkg::ONE_Q;
         err_sum       = '0;
         doc_rank      = errac_pkg::RANK_ONE;
         expected_scores.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_scores.size() == 0) begin
               report_mismatch("with no request waiting", 64'(rsp_tdata), 64'd0);
            end else begin
               want = expected_scores.pop_front();
               if (rsp_tdata[32:0] !== want.err)
                  report_mismatch("err_value", 64'(rsp_tdata[32:0]), 64'(want.err));
               if (rsp_tdata[48:33] !== want.rank)
                  report_mismatch("rank_out", 64'(rsp_tdata[48:33]), 64'(want.rank));
               if (rsp_tlast !== want.final_doc)
                  report_mismatch("is_final", 64'(rsp_tlast), 64'(want.final_doc));
               if (rsp_tdata[55:49] !== 7'd0)
                  report_mismatch("padding", 64'(rsp_tdata[55:49]), 64'd0);
            end
         end
         if (req_tvalid && req_tready)
            expected_scores.push_back(score_document(req_tdata[3:0], req_tlast));
         if (csr_valid && csr_ready)
            level_count = csr_data;
      end
      pending <= expected_scores.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ERR accumulator testbench
// Drives ranked documents through the accumulator under several level
// counts, with random idling on both channels, and reports the verdict.
// ---------------------------------------------------------------------------
module testbench;

   // A stall of this many cycles with no handshake anywhere means the block has hung.
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES      = 12;
   localparam int PHASE_DOCS  = 86;
   localparam int DRAIN       = 60;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data   = 5'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [3:0] doc_grade, [7:4] zero
   logic        req_tlast  = 1'b0;   // query_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;           // [32:0] err_value, [48:33] rank_out, [55:49] zero
   logic        rsp_tlast;           // is_final

   int   pending;
   int   mismatch_count;
   int   quiet_cycles = 0;
   int   stall_left   = 0;
   logic pace_jitter  = 1'b1;

   // Level counts visited by the random phases; the last phase draws its own.
   // Out-of-range settings above sixteen are among them.
   logic [4:0] level_plan [0:PHASES-2] = '{5'd31, 5'd2, 5'd4, 5'd5, 5'd8, 5'd16,
                                           5'd1, 5'd17, 5'd11, 5'd6, 5'd13};

   always #1 clock = ~clock;

   expected_reciprocal_rank_accum u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   err_response_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .pending        (pending),
      .mismatch_count (mismatch_count)
   );

   // Response side back-pressure: random stalls while jitter is enabled,
   // always ready otherwise.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (pace_jitter && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hang detection: any accepted request on any channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one document and returns at the edge where it is accepted. The
   // valid stays high afterwards so that back-to-back requests never lower
   // and raise it within one time step; a gap lowers it first.
   task automatic send_document(input logic [3:0] level, input logic closes_query);
      int gap;
      if (pace_jitter && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, level};
      req_tlast  <= closes_query;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering documents and waits until every response has come back.
   task automatic settle_queries();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // The level count is only written while the block has nothing in flight.
   task automatic write_levels(input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int qlen;
      logic [3:0] level;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default six levels: every level in rank order within one query, so
      // levels above the scale get clamped, then a one-document query.
      for (int lvl = 0; lvl < 16; lvl++)
         send_document(4'(lvl), lvl == 15);
      send_document(4'd5, 1'b1);

      // Sixteen levels: the largest gain, the smallest nonzero gain, a level at
      // the gain floor, then the largest gain again once the stay probability has dropped.
      settle_queries();
      write_levels(5'd16);
      send_document(4'd15, 1'b0);
      send_document(4'd4, 1'b0);
      send_document(4'd3, 1'b0);
      send_document(4'd15, 1'b1);

      // A single level gives no gain at all, and zero levels acts as one.
      settle_queries();
      write_levels(5'd1);
      send_document(4'd15, 1'b0);
      send_document(4'd9, 1'b1);
      settle_queries();
      write_levels(5'd0);
      send_document(4'd12, 1'b1);

      // Random phases. Queries are mostly short with the occasional long one;
      // a phase may end in the middle of a query, whose state then carries
      // over into the next level count. The last two phases run without
      // idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         pace_jitter <= (phase < PHASES - 2);
         settle_queries();
         if (phase < PHASES - 1)
            write_levels(level_plan[phase]);
         else
            write_levels(5'($urandom_range(0, 31)));
         sent = 0;
         while (sent < PHASE_DOCS) begin
            if ($urandom_range(0, 9) == 0)
               qlen = $urandom_range(30, 150);
            else
               qlen = $urandom_range(1, 12);
            for (int k = 0; k < qlen && sent < PHASE_DOCS; k++) begin
               // Weight the top level so that the stay probability sinks
               // quickly and ERR climbs toward one.
               if ($urandom_range(0, 3) == 0)
                  level = 4'd15;
               else
                  level = 4'($urandom_range(0, 15));
               send_document(level, k == qlen - 1);
               sent++;
            end
         end
      end

      settle_queries();
      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
